// ===== sv/tswo_pkg.sv =====
// Package for the trace SWO packet decoder: decoder state codes, result kinds,
// default sizes and the output word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tswo_pkg;

	// default sizes
	localparam int PROTO_MAX_BYTES_DEF = 7;
	localparam int SYNC_ZERO_COUNT_DEF = 5;

	// fixed field widths of the result word
	localparam int PROTO_OUT_BYTES = 7;
	localparam int TDATA_W         = 104;
	localparam int TUSER_W         = 2;

	// sync marker that follows the zero run
	localparam logic [7:0] SYNC_MARK = 8'h80;

	// result kinds, carried on tuser
	localparam logic [1:0] KIND_SYNC   = 2'd0;
	localparam logic [1:0] KIND_SOURCE = 2'd1;
	localparam logic [1:0] KIND_PROTO  = 2'd2;

	// decoder states; the first four match header bits 1..0 of a source header
	localparam logic [3:0] ST_UNSYNC  = 4'd0;
	localparam logic [3:0] ST_SRC1_B0 = 4'd1;
	localparam logic [3:0] ST_SRC2_B0 = 4'd2;
	localparam logic [3:0] ST_SRC4_B0 = 4'd3;
	localparam logic [3:0] ST_SRC2_B1 = 4'd4;
	localparam logic [3:0] ST_SRC4_B1 = 4'd5;
	localparam logic [3:0] ST_SRC4_B2 = 4'd6;
	localparam logic [3:0] ST_SRC4_B3 = 4'd7;
	localparam logic [3:0] ST_PROTO   = 4'd8;
	localparam logic [3:0] ST_IDLE    = 4'd9;

	// one decoded result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  source_address;
		logic        hardware_source;
		logic [2:0]  payload_bytes;
		logic [31:0] payload_value;
		logic [2:0]  protocol_length;
		logic [55:0] protocol_bytes;
	} tswo_result_t;

endpackage

`default_nettype wire

// ===== sv/trace_swo_packet_decoder.sv =====
// Trace SWO packet decoder top level: byte stream in, decoded packet words out.
// Depends on tswo_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes an ITM-style trace byte stream, one byte per word on the slave side.
// The decoder starts unsynchronised and locks when SYNC_ZERO_COUNT or more zero
// bytes are followed by 0x80; that sequence also resynchronises in the middle of
// a packet. A word appears on the master side for each sync found, each source
// packet completed (address, hardware flag, 1/2/4 byte little-endian payload) and
// each protocol packet completed (up to PROTO_MAX_BYTES bytes, continued while
// bit 7 is set). A source header with size bits 00 drops the decoder back to
// unsynchronised without a word. Throughput is one byte per clock while the
// master side takes its words: a byte is held in an input register, the state
// step runs on the held byte and its word lands in an output register, which
// drives the master side. Output stalls back up through the input register only
// while the output register holds an untaken word.
module trace_swo_packet_decoder
	import tswo_pkg::*;
#(
	parameter int PROTO_MAX_BYTES = PROTO_MAX_BYTES_DEF,  // 2..7
	parameter int SYNC_ZERO_COUNT = SYNC_ZERO_COUNT_DEF   // 1..7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// slave side: tdata = trace_byte[7:0]
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic [7:0]         s_tdata,
	// master side
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	// tdata, from bit 0: source_address[4:0], hardware_source, payload_bytes[2:0],
	// payload_value[31:0], protocol_length[2:0], protocol_bytes[55:0], 4 zero bits
	output      logic [TDATA_W-1:0] m_tdata,
	// tuser = packet_kind[1:0]
	output      logic [TUSER_W-1:0] m_tuser
);

	localparam int ZW = $clog2(SYNC_ZERO_COUNT + 1);
	localparam int CW = $clog2(PROTO_MAX_BYTES + 1);
	localparam int IW = $clog2(PROTO_MAX_BYTES);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state
	logic [3:0]    st_q, st_d;
	logic [ZW-1:0] zero_run_q, zero_run_d;
	logic [5:0]    tag_q, tag_d;
	logic [23:0]   part_q, part_d;
	logic [7:0]    buf_q [PROTO_MAX_BYTES];
	logic [7:0]    buf_d [PROTO_MAX_BYTES];
	logic [CW-1:0] cnt_q, cnt_d;

	// output register
	logic         out_valid_q;
	tswo_result_t res_q;

	// step logic
	logic         adv;
	logic         res_v;
	logic         emit_src, emit_proto;
	logic [2:0]   src_n;
	logic [31:0]  src_val;
	logic [CW-1:0] plen;
	logic [55:0]  pbytes;
	tswo_result_t res_d;

	// handshake: the input register moves on when the output register is free or its word is being taken
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// one decoder step on the held byte
	always_comb begin
		st_d       = st_q;
		zero_run_d = zero_run_q;
		tag_d      = tag_q;
		part_d     = part_q;
		buf_d      = buf_q;
		cnt_d      = cnt_q;
		res_v      = 1'b0;
		emit_src   = 1'b0;
		emit_proto = 1'b0;
		src_n      = 3'd0;
		src_val    = 32'd0;
		plen       = cnt_q;

		// zero run, saturating
		if (byte_s1 == 8'd0) begin
			if (zero_run_q < ZW'(SYNC_ZERO_COUNT)) begin
				zero_run_d = zero_run_q + ZW'(1);
			end
		end else begin
			zero_run_d = '0;
		end

		if (byte_s1 == SYNC_MARK && zero_run_q >= ZW'(SYNC_ZERO_COUNT)) begin
			st_d  = ST_IDLE;
			res_v = 1'b1;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (byte_s1[2:0] != 3'd0) begin
						tag_d  = {byte_s1[2], byte_s1[7:3]};
						part_d = '0;
						st_d   = {2'b00, byte_s1[1:0]};
					end else if (byte_s1 != 8'd0) begin
						buf_d[0] = byte_s1;
						if (byte_s1[7]) begin
							cnt_d = CW'(1);
							st_d  = ST_PROTO;
						end else begin
							plen       = CW'(1);
							emit_proto = 1'b1;
						end
					end
				end
				ST_PROTO: begin
					if (cnt_q < CW'(PROTO_MAX_BYTES)) begin
						buf_d[cnt_q[IW-1:0]] = byte_s1;
					end
					cnt_d = cnt_q + CW'(1);
					plen  = cnt_d;
					if (cnt_d >= CW'(PROTO_MAX_BYTES) || !byte_s1[7]) begin
						st_d       = ST_IDLE;
						emit_proto = 1'b1;
					end
				end
				ST_SRC1_B0: begin
					st_d     = ST_IDLE;
					emit_src = 1'b1;
					src_n    = 3'd1;
					src_val  = {24'd0, byte_s1};
				end
				ST_SRC2_B0: begin
					part_d = {16'd0, byte_s1};
					st_d   = ST_SRC2_B1;
				end
				ST_SRC2_B1: begin
					st_d     = ST_IDLE;
					emit_src = 1'b1;
					src_n    = 3'd2;
					src_val  = {16'd0, byte_s1, part_q[7:0]};
				end
				ST_SRC4_B0: begin
					part_d = {16'd0, byte_s1};
					st_d   = ST_SRC4_B1;
				end
				ST_SRC4_B1: begin
					part_d = {8'd0, byte_s1, part_q[7:0]};
					st_d   = ST_SRC4_B2;
				end
				ST_SRC4_B2: begin
					part_d = {byte_s1, part_q[15:0]};
					st_d   = ST_SRC4_B3;
				end
				ST_SRC4_B3: begin
					st_d     = ST_IDLE;
					emit_src = 1'b1;
					src_n    = 3'd4;
					src_val  = {byte_s1, part_q};
				end
				default: begin
					// unsynchronised: bytes only feed the zero run
				end
			endcase
			res_v = emit_src || emit_proto;
		end
	end

	// protocol bytes: only the first plen bytes of the buffer count
	for (genvar g = 0; g < PROTO_OUT_BYTES; g++) begin : g_pbyte
		if (g < PROTO_MAX_BYTES) begin : g_used
			assign pbytes[8*g +: 8] = (CW'(g) < plen) ? buf_d[g] : 8'd0;
		end else begin : g_unused
			assign pbytes[8*g +: 8] = 8'd0;
		end
	end

	// result word, other kinds' fields zero
	always_comb begin
		res_d = '0;
		if (emit_src) begin
			res_d.kind            = KIND_SOURCE;
			res_d.source_address  = tag_q[4:0];
			res_d.hardware_source = tag_q[5];
			res_d.payload_bytes   = src_n;
			res_d.payload_value   = src_val;
		end else if (emit_proto) begin
			res_d.kind            = KIND_PROTO;
			res_d.protocol_length = 3'(plen);
			res_d.protocol_bytes  = pbytes;
		end else begin
			res_d.kind            = KIND_SYNC;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_UNSYNC;
			zero_run_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q       <= st_d;
				zero_run_q <= zero_run_d;
			end
			if (adv) begin
				out_valid_q <= res_v;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// packet state and result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q  <= tag_d;
			part_q <= part_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
			if (res_v) begin
				res_q <= res_d;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {4'd0, res_q.protocol_bytes, res_q.protocol_length,
		res_q.payload_value, res_q.payload_bytes, res_q.hardware_source,
		res_q.source_address};

endmodule

`default_nettype wire

// ===== tb/trace_swo_packet_decoder_tb.sv =====
`timescale 1ns / 1ps
// Testbench for trace_swo_packet_decoder: streams trace bytes in and checks each
// decoded word against a built-in decoder model kept in a small scoreboard class.
// Depends on tswo_pkg and the decoder RTL.

module trace_swo_packet_decoder_tb;
	import tswo_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RAND_ITEMS   = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int DRAIN_LIMIT  = 100000;
	localparam int MAX_REPORTS  = 10;
	localparam int N_DIRECTED   = 32;

	// directed bytes: near-miss sync while unsynchronised, sync on a saturated zero run,
	// ignored zero header, 1/2/4 byte source packets at extremes, single and
	// maximum-length protocol packets, and a size-00 source header
	localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
		8'h00, 8'hF9, 8'hFF,
		8'h06, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hFF,
		8'h70,
		8'h80, 8'hFF, 8'h81, 8'h82, 8'h83, 8'h84, 8'hFF,
		8'h0C
	};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	// decoder model plus the queue of decoded words still to arrive
	class swo_decode_scoreboard;
		logic [3:0]   state;
		int           zero_run;
		logic [4:0]   src_addr;
		logic         src_hw;
		logic [31:0]  partial;
		logic [7:0]   proto_buf [PROTO_MAX_BYTES_DEF];
		int           proto_count;
		tswo_result_t expected_words [$];
		int           errors;

		function new();
			state       = ST_UNSYNC;
			zero_run    = 0;
			src_addr    = '0;
			src_hw      = 1'b0;
			partial     = '0;
			proto_count = 0;
			errors      = 0;
			foreach (proto_buf[i]) proto_buf[i] = '0;
		endfunction

		function tswo_result_t source_word(input logic [31:0] value, input logic [2:0] nbytes);
			tswo_result_t w;
			w                 = '0;
			w.kind            = KIND_SOURCE;
			w.source_address  = src_addr;
			w.hardware_source = src_hw;
			w.payload_bytes   = nbytes;
			w.payload_value   = value;
			return w;
		endfunction

		function tswo_result_t proto_word(input int len);
			tswo_result_t w;
			w                 = '0;
			w.kind            = KIND_PROTO;
			w.protocol_length = len[2:0];
			for (int i = 0; i < len && i < PROTO_MAX_BYTES_DEF; i++)
				w.protocol_bytes[8*i +: 8] = proto_buf[i];
			return w;
		endfunction

		// one accepted trace byte: step the model, queue any word it produces
		function void take_byte(input logic [7:0] x);
			tswo_result_t w;
			bit           emits;
			w     = '0;
			emits = 1'b0;
			// sync detection runs ahead of the packet state
			if (x == 8'h00) begin
				if (zero_run < SYNC_ZERO_COUNT_DEF)
					zero_run++;
			end else if (zero_run >= SYNC_ZERO_COUNT_DEF && x == SYNC_MARK) begin
				state    = ST_IDLE;
				zero_run = 0;
				w.kind   = KIND_SYNC;
				expected_words.push_back(w);
				return;
			end else begin
				zero_run = 0;
			end
			case (state)
				ST_IDLE: begin
					if (x[2:0] != 3'b000) begin
						src_addr = x[7:3];
						src_hw   = x[2];
						partial  = '0;
						case (x[1:0])
							2'b01:   state = ST_SRC1_B0;
							2'b10:   state = ST_SRC2_B0;
							2'b11:   state = ST_SRC4_B0;
							default: state = ST_UNSYNC;
						endcase
					end else if (x != 8'h00) begin
						proto_buf[0] = x;
						if (x[7]) begin
							proto_count = 1;
							state       = ST_PROTO;
						end else begin
							w     = proto_word(1);
							emits = 1'b1;
						end
					end
				end
				ST_PROTO: begin
					if (proto_count < PROTO_MAX_BYTES_DEF)
						proto_buf[proto_count] = x;
					proto_count++;
					if (proto_count >= PROTO_MAX_BYTES_DEF || !x[7]) begin
						state = ST_IDLE;
						w     = proto_word(proto_count);
						emits = 1'b1;
					end
				end
				ST_SRC1_B0: begin
					state = ST_IDLE;
					w     = source_word({24'h0, x}, 3'd1);
					emits = 1'b1;
				end
				ST_SRC2_B0: begin
					partial[7:0] = x;
					state        = ST_SRC2_B1;
				end
				ST_SRC2_B1: begin
					state = ST_IDLE;
					w     = source_word({16'h0, x, partial[7:0]}, 3'd2);
					emits = 1'b1;
				end
				ST_SRC4_B0: begin
					partial[7:0] = x;
					state        = ST_SRC4_B1;
				end
				ST_SRC4_B1: begin
					partial[15:8] = x;
					state         = ST_SRC4_B2;
				end
				ST_SRC4_B2: begin
					partial[23:16] = x;
					state          = ST_SRC4_B3;
				end
				ST_SRC4_B3: begin
					state = ST_IDLE;
					w     = source_word({x, partial[23:0]}, 3'd4);
					emits = 1'b1;
				end
				default: ;
			endcase
			if (emits)
				expected_words.push_back(w);
		endfunction

		// one accepted output word: compare every field with the oldest expectation
		function void check_word(input logic [TUSER_W-1:0] kind, input logic [TDATA_W-1:0] data);
			tswo_result_t got;
			tswo_result_t want;
			logic [3:0]   pad;
			got.kind            = kind;
			got.source_address  = data[4:0];
			got.hardware_source = data[5];
			got.payload_bytes   = data[8:6];
			got.payload_value   = data[40:9];
			got.protocol_length = data[43:41];
			got.protocol_bytes  = data[99:44];
			pad                 = data[103:100];
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("Unexpected word: kind=%0d addr=%0d hw=%0d nb=%0d val=%h len=%0d prot=%h",
						got.kind, got.source_address, got.hardware_source, got.payload_bytes,
						got.payload_value, got.protocol_length, got.protocol_bytes);
				return;
			end
			want = expected_words.pop_front();
			if (got.kind !== want.kind || got.source_address !== want.source_address ||
				got.hardware_source !== want.hardware_source ||
				got.payload_bytes !== want.payload_bytes ||
				got.payload_value !== want.payload_value ||
				got.protocol_length !== want.protocol_length ||
				got.protocol_bytes !== want.protocol_bytes || pad !== 4'h0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("Mismatch exp: kind=%0d addr=%0d hw=%0d nb=%0d val=%h len=%0d prot=%h",
						want.kind, want.source_address, want.hardware_source, want.payload_bytes,
						want.payload_value, want.protocol_length, want.protocol_bytes);
					$display("         got: kind=%0d addr=%0d hw=%0d nb=%0d val=%h len=%0d prot=%h pad=%h",
						got.kind, got.source_address, got.hardware_source, got.payload_bytes,
						got.payload_value, got.protocol_length, got.protocol_bytes, pad);
				end
			end
		endfunction
	endclass

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;

	idle_mode_e           idle_mode = IDLE_BOTH;
	swo_decode_scoreboard sb        = new();

	trace_swo_packet_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 81;
			IDLE_BOTH:   return $urandom_range(0, 99) < 17;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 81;
			IDLE_BOTH:     return $urandom_range(0, 99) < 17;
			default:       return 1'b0;
		endcase
	endfunction

	// payload content, leaning towards the all-zero and all-one extremes
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// master side: random back-pressure, check every accepted word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata);
		m_tready <= !receiver_stalls();
	end

	// present one byte, hold it until taken; valid is only lowered for a gap
	task automatic send_byte(input logic [7:0] b);
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_byte(b);
	endtask

	// mostly well-formed syncs and packets with random content, some broken ones and noise
	task automatic send_random_traffic(input int quota);
		int         sent;
		int         pick;
		int         len;
		logic [7:0] b;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				// zero run, one short of sync now and then, then the marker
				len = $urandom_range(SYNC_ZERO_COUNT_DEF - 1, SYNC_ZERO_COUNT_DEF + 2);
				for (int k = 0; k < len; k++)
					send_byte(8'h00);
				send_byte(SYNC_MARK);
				sent += len + 1;
			end else if (pick < 55) begin
				// source packet
				b      = 8'($urandom_range(0, 255));
				b[1:0] = 2'($urandom_range(1, 3));
				send_byte(b);
				len = (b[1:0] == 2'b11) ? 4 : int'(b[1:0]);
				for (int k = 0; k < len; k++)
					send_byte(payload_byte());
				sent += len + 1;
			end else if (pick < 88) begin
				// protocol packet, sometimes one byte past the maximum
				len    = $urandom_range(1, PROTO_MAX_BYTES_DEF + 1);
				b      = 8'($urandom_range(0, 255));
				b[2:0] = 3'b000;
				b[7]   = (len > 1);
				if (b == 8'h00)
					b[3] = 1'b1;
				send_byte(b);
				for (int k = 1; k < len; k++) begin
					b    = payload_byte();
					b[7] = (k < len - 1);
					send_byte(b);
				end
				sent += len;
			end else if (pick < 93) begin
				// source header with size bits 00
				b      = 8'($urandom_range(0, 255));
				b[2:0] = 3'b100;
				send_byte(b);
				sent++;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// stimulus and end of run
	initial begin
		int drain;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED_BYTES[i]);

		idle_mode = IDLE_NONE;
		send_random_traffic(RAND_ITEMS / 4);
		idle_mode = IDLE_SENDER;
		send_random_traffic(RAND_ITEMS / 4);
		idle_mode = IDLE_RECEIVER;
		send_random_traffic(RAND_ITEMS / 4);
		idle_mode = IDLE_BOTH;
		send_random_traffic(RAND_ITEMS / 4);
		s_tvalid <= 1'b0;

		drain = 0;
		while (sb.expected_words.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			if (sb.expected_words.size() != 0)
				$display("%0d expected words never arrived", sb.expected_words.size());
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tswo_pkg.sv
sv/trace_swo_packet_decoder.sv
tb/trace_swo_packet_decoder_tb.sv
